// ===== hdl/kje_pkg.sv =====
// Shared types, codes and lookup functions for the keypad joystick emulator.
// No dependencies; included by every module of the block.
`timescale 1ns / 1ps

package kje_pkg;

  localparam int NUM_KEYS   = 11;
  localparam int NUM_DIRS   = 9;
  localparam int QUOT_W     = 7;
  localparam int REM_W      = 9;
  localparam int DIV_STEPS  = QUOT_W;

  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TRIM = 1'b1;

  localparam logic [3:0] KEY_BUTTON0 = 4'd9;
  localparam logic [3:0] KEY_BUTTON1 = 4'd10;
  localparam logic [3:0] KEY_LAST    = 4'd10;

  localparam logic [3:0] TRIM_Y_INC = 4'd1;
  localparam logic [3:0] TRIM_X_DEC = 4'd3;
  localparam logic [3:0] TRIM_CLEAR = 4'd4;
  localparam logic [3:0] TRIM_X_INC = 4'd5;
  localparam logic [3:0] TRIM_Y_DEC = 4'd7;

  localparam logic [2:0] PORT_KEYB_STD    = 3'd2;
  localparam logic [2:0] PORT_KEYB_CENTER = 3'd3;

  localparam logic       REG_FIRST_PORT  = 1'b0;
  localparam logic       REG_SECOND_PORT = 1'b1;

  localparam logic signed [7:0] TRIM_MAX   = 8'sd64;
  localparam logic signed [7:0] TRIM_MIN   = -8'sd64;
  localparam logic        [7:0] CENTRE_POS = 8'd127;

  typedef struct packed {
    logic       command;
    logic [3:0] key_index;
    logic       pressed;
    logic       auto_repeat;
    logic       extended_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] target;
    logic       axis_select;
    logic [7:0] value;
    logic       handled;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_step;
    logic [2:0] div_bit;
    logic       emit;
    logic       emit_sel;
  } kje_cmd_t;

  typedef struct packed {
    logic is_axis;
    logic two_results;
    logic out_free;
  } kje_status_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] key;
  } corner_t;

  // Corner lookup on the released flags of the four orthogonal keys.
  function automatic corner_t corner_lookup(input logic [3:0] released);
    corner_t c;
    c.hit = 1'b1;
    unique case (released)
      4'd3:    c.key = 4'd8;
      4'd5:    c.key = 4'd6;
      4'd10:   c.key = 4'd2;
      4'd12:   c.key = 4'd0;
      default: begin
        c.hit = 1'b0;
        c.key = 4'd0;
      end
    endcase
    return c;
  endfunction

  function automatic logic is_keyboard(input logic [2:0] port_type);
    return (port_type == PORT_KEYB_STD) || (port_type == PORT_KEYB_CENTER);
  endfunction

endpackage

// ===== hdl/kje_ctrl.sv =====
// Sequencer for the keypad joystick emulator: accept, plan, divide, emit.
// Depends on kje_pkg for the command and status structs.
`timescale 1ns / 1ps

module kje_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kje_pkg::kje_status_t status,
  output kje_pkg::kje_cmd_t    cmd
);
  import kje_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_DIV,
    S_EMIT0,
    S_EMIT1
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.div_bit = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        if (status.is_axis) begin
          cmd.div_start = 1'b1;
          cnt_next      = 3'(DIV_STEPS - 1);
          state_next    = S_DIV;
        end else begin
          state_next = S_EMIT0;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 3'd0) begin
          state_next = S_EMIT0;
        end else begin
          cnt_next = cnt - 3'd1;
        end
      end
      S_EMIT0: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.two_results ? S_EMIT1 : S_IDLE;
        end
      end
      S_EMIT1: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== hdl/kje_dp.sv =====
// Datapath: key and trim state, port configuration, axis divider, result register.
// Depends on kje_pkg; driven by kje_ctrl through kje_cmd_t.
`timescale 1ns / 1ps

module kje_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  kje_pkg::in_item_t    in_item,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [2:0]           cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output kje_pkg::out_item_t   out_item,
  input  kje_pkg::kje_cmd_t    cmd,
  output kje_pkg::kje_status_t status
);
  import kje_pkg::*;

  logic [2:0]             port0;
  logic [2:0]             port1;
  logic [NUM_KEYS-1:0]    key_held;
  logic signed [7:0]      trim_x;
  logic signed [7:0]      trim_y;
  in_item_t               item;

  logic [REM_W-1:0]       rem_x;
  logic [REM_W-1:0]       rem_y;
  logic [3:0]             dvs;
  logic [QUOT_W-1:0]      q_x;
  logic [QUOT_W-1:0]      q_y;
  logic                   sgn_x;
  logic                   sgn_y;

  corner_t                corner;
  logic [NUM_DIRS-1:0]    sel;
  logic [1:0]             x_pos;
  logic [1:0]             x_neg;
  logic [1:0]             y_pos;
  logic [1:0]             y_neg;
  logic [1:0]             x_mag;
  logic [1:0]             y_mag;
  logic [3:0]             n_held;
  logic [9:0]             trial;
  logic [7:0]             x_val;
  logic [7:0]             y_val;
  logic                   joy;
  logic                   trim_ok;
  out_item_t              r0;
  out_item_t              r1;

  // Configuration and held-key / trim state.
  always_ff @(posedge clk) begin
    if (rst) begin
      port0    <= '0;
      port1    <= '0;
      key_held <= '0;
      trim_x   <= '0;
      trim_y   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FIRST_PORT:  port0 <= cfg_data;
          REG_SECOND_PORT: port1 <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (in_item.command == CMD_TRIM) begin
          case (in_item.key_index)
            TRIM_Y_INC: if (trim_y < TRIM_MAX) trim_y <= trim_y + 8'sd1;
            TRIM_X_DEC: if (trim_x > TRIM_MIN) trim_x <= trim_x - 8'sd1;
            TRIM_X_INC: if (trim_x < TRIM_MAX) trim_x <= trim_x + 8'sd1;
            TRIM_Y_DEC: if (trim_y > TRIM_MIN) trim_y <= trim_y - 8'sd1;
            TRIM_CLEAR: begin
              trim_x <= '0;
              trim_y <= '0;
            end
            default: ;
          endcase
        end else if (!in_item.extended_key && in_item.key_index <= KEY_LAST) begin
          key_held[in_item.key_index] <= in_item.pressed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
  end

  // Direction mix: corner key alone, else every held direction key.
  always_comb begin
    corner = corner_lookup({~key_held[7], ~key_held[5], ~key_held[3], ~key_held[1]});
    sel    = corner.hit ? (NUM_DIRS'(1) << corner.key) : key_held[NUM_DIRS-1:0];
    x_pos  = 2'(sel[2]) + 2'(sel[5]) + 2'(sel[8]);
    x_neg  = 2'(sel[0]) + 2'(sel[3]) + 2'(sel[6]);
    y_pos  = 2'(sel[0]) + 2'(sel[1]) + 2'(sel[2]);
    y_neg  = 2'(sel[6]) + 2'(sel[7]) + 2'(sel[8]);
    x_mag  = (x_neg > x_pos) ? (x_neg - x_pos) : (x_pos - x_neg);
    y_mag  = (y_neg > y_pos) ? (y_neg - y_pos) : (y_pos - y_neg);
    n_held = '0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      n_held = n_held + 4'(sel[i]);
    end
  end

  // Restoring divide of 127*|d| by the key count, one quotient bit per step.
  assign trial = 10'(dvs) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_x <= {x_mag, 7'b0} - REM_W'(x_mag);
      rem_y <= {y_mag, 7'b0} - REM_W'(y_mag);
      dvs   <= (n_held == 4'd0) ? 4'd1 : n_held;
      sgn_x <= (x_neg > x_pos);
      sgn_y <= (y_neg > y_pos);
      q_x   <= '0;
      q_y   <= '0;
    end else if (cmd.div_step) begin
      if ({1'b0, rem_x} >= trial) begin
        rem_x          <= rem_x - trial[REM_W-1:0];
        q_x[cmd.div_bit] <= 1'b1;
      end
      if ({1'b0, rem_y} >= trial) begin
        rem_y          <= rem_y - trial[REM_W-1:0];
        q_y[cmd.div_bit] <= 1'b1;
      end
    end
  end

  assign x_val = CENTRE_POS + $unsigned(trim_x) + (sgn_x ? -{1'b0, q_x} : {1'b0, q_x});
  assign y_val = CENTRE_POS + $unsigned(trim_y) + (sgn_y ? -{1'b0, q_y} : {1'b0, q_y});
  assign joy   = !is_keyboard(port0);

  // Result plan for the held request.
  always_comb begin
    r0 = '{kind: KIND_STATUS, target: 2'd0, axis_select: 1'b0, value: 8'd0,
           handled: 1'b1, last: 1'b1};
    r1 = r0;
    status.is_axis     = 1'b0;
    status.two_results = 1'b0;
    status.out_free    = !out_valid || !out_stall;
    trim_ok = (item.key_index == TRIM_Y_INC) || (item.key_index == TRIM_X_DEC) ||
              (item.key_index == TRIM_CLEAR) || (item.key_index == TRIM_X_INC) ||
              (item.key_index == TRIM_Y_DEC);
    if (item.command == CMD_TRIM) begin
      r0.handled = trim_ok;
    end else if (item.extended_key || item.key_index > KEY_LAST) begin
      r0.handled = 1'b0;
    end else if (item.key_index == KEY_BUTTON0) begin
      r0.kind  = KIND_BUTTON;
      r0.value = 8'(item.pressed);
      if (is_keyboard(port1)) begin
        r0.target          = 2'd2;
        r0.last            = 1'b0;
        r1                 = r0;
        r1.target          = 2'd1;
        r1.last            = 1'b1;
        status.two_results = 1'b1;
      end
    end else if (item.key_index == KEY_BUTTON1) begin
      if (!is_keyboard(port1)) begin
        r0.kind   = KIND_BUTTON;
        r0.target = 2'd1;
        r0.value  = 8'(item.pressed);
      end
    end else if ((item.pressed && !item.auto_repeat) ||
                 ((joy ? port1 : port0) == PORT_KEYB_CENTER)) begin
      status.is_axis     = 1'b1;
      status.two_results = 1'b1;
      r0 = '{kind: KIND_AXIS, target: 2'(joy), axis_select: 1'b0, value: x_val,
             handled: 1'b1, last: 1'b0};
      r1 = '{kind: KIND_AXIS, target: 2'(joy), axis_select: 1'b1, value: y_val,
             handled: 1'b1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item <= cmd.emit_sel ? r1 : r0;
    end
  end

endmodule

// ===== hdl/keypad_joystick_emulator.sv =====
// Top level of the keypad joystick emulator.
// Depends on kje_pkg, kje_ctrl and kje_dp.
`timescale 1ns / 1ps
//
// Usage:
//   in channel  : in_valid / in_stall / in_item, one key or trim request per
//                 handshake. in_stall is high while a request is in work.
//   out channel : out_valid / out_stall / out_item, one or two results per
//                 request; the final one has last set.
//   config      : cfg_write / cfg_index / cfg_data write the port types;
//                 write only while no request is in work.
// Sequence: an accepted request passes S_PLAN, then for axis writes the
//   seven-step restoring divider in S_DIV that averages the held direction
//   keys, then S_EMIT0 registers the first result and S_EMIT1 the second.
// Overlap: the next request is taken while the last result still waits in
//   the output register.
// Reset: all keys released, trims zero, both port types zero, output empty.
// Stall: a stalled result holds in the output register and the sequencer
//   waits in S_EMIT0 or S_EMIT1 before loading the next result into it.

module keypad_joystick_emulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kje_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output kje_pkg::out_item_t out_item,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data
);
  import kje_pkg::*;

  kje_cmd_t    cmd;
  kje_status_t status;

  kje_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kje_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== hdl/kje_checker.sv =====
// Port-level checks for the keypad joystick emulator, bound to the top level.
// Depends on kje_pkg for the result struct and kind codes.
`timescale 1ns / 1ps

module kje_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input kje_pkg::out_item_t out_item
);
  import kje_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_STATUS |->
      out_item.target == 2'd0 && !out_item.axis_select && out_item.value == 8'd0)
    else $error("status result carries payload");

  a_axis_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_AXIS |-> out_item.axis_select == out_item.last)
    else $error("axis result out of order");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind keypad_joystick_emulator kje_checker u_kje_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
